/* hdl/adrp_pkg.sv */
package adrp_pkg;

  // Default length of the search window, counted from the ADRP itself.
  localparam int unsigned WindowLenDefault = 16;

  // Instruction encodings.
  localparam logic [31:0] AdrpMask = 32'h9F00_0000;
  localparam logic [31:0] AdrpCode = 32'h9000_0000;
  localparam logic [31:0] OpcMask  = 32'hFFC0_0000;
  localparam logic [31:0] AddCode  = 32'h9100_0000;
  localparam logic [31:0] LdrxCode = 32'hF940_0000;
  localparam logic [31:0] LdrwCode = 32'hB940_0000;

  // Instruction classes that can complete a pair.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_LDRX = 2'd2,
    OP_LDRW = 2'd3
  } op_class_e;

  // Fields pulled out of one instruction word.
  typedef struct packed {
    logic        is_adrp;
    logic [4:0]  rd;
    logic [4:0]  rn;
    op_class_e   op;
    logic [20:0] imm21;
    logic [11:0] imm12;
  } decode_t;

  // Contents of the input register.
  typedef struct packed {
    logic        req_start;
    logic        in_text;
    logic [31:0] word;
    logic [63:0] pc_page;
  } stage_t;

endpackage

/* hdl/adrp_decode.sv */
module adrp_decode (
  input  logic [31:0]             word_i,
  output adrp_pkg::decode_t       dec_o
);

  always_comb begin
    dec_o.is_adrp = ((word_i & adrp_pkg::AdrpMask) == adrp_pkg::AdrpCode);
    dec_o.rd      = word_i[4:0];
    dec_o.rn      = word_i[9:5];
    // immhi sits in bits 23..5, immlo in bits 30..29.
    dec_o.imm21   = {word_i[23:5], word_i[30:29]};
    dec_o.imm12   = word_i[21:10];
    unique case (word_i & adrp_pkg::OpcMask)
      adrp_pkg::AddCode:  dec_o.op = adrp_pkg::OP_ADD;
      adrp_pkg::LdrxCode: dec_o.op = adrp_pkg::OP_LDRX;
      adrp_pkg::LdrwCode: dec_o.op = adrp_pkg::OP_LDRW;
      default:            dec_o.op = adrp_pkg::OP_NONE;
    endcase
  end

endmodule

/* hdl/adrp_search.sv */
module adrp_search #(
  parameter int unsigned WINDOW_LEN = adrp_pkg::WindowLenDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  adrp_pkg::stage_t  stage_i,
  input  adrp_pkg::decode_t dec_i,
  input  logic              advance_i,
  output logic              emit_o,
  output logic [63:0]       addr_o,
  output logic              found_o
);

  localparam int unsigned CntW = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WINDOW_LEN - 1);
  localparam logic [CntW-1:0] CntFirst = CntW'(1);

  logic            active_q, active_d;
  logic [63:0]     page_q, page_d;
  logic [4:0]      dest_q, dest_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [14:0]     off_scaled;

  always_comb begin
    unique case (dec_i.op)
      adrp_pkg::OP_LDRX: off_scaled = {dec_i.imm12, 3'b000};
      adrp_pkg::OP_LDRW: off_scaled = {1'b0, dec_i.imm12, 2'b00};
      adrp_pkg::OP_ADD:  off_scaled = {3'b000, dec_i.imm12};
      default:           off_scaled = {3'b000, dec_i.imm12};
    endcase
  end

  always_comb begin
    active_d = active_q;
    page_d   = page_q;
    dest_d   = dest_q;
    cnt_d    = cnt_q;
    emit_o   = 1'b0;
    found_o  = 1'b0;
    addr_o   = '0;
    if (stage_i.req_start) begin
      if (!stage_i.in_text || !dec_i.is_adrp) begin
        active_d = 1'b0;
        emit_o   = 1'b1;
      end else begin
        active_d = 1'b1;
        page_d   = stage_i.pc_page + {{31{dec_i.imm21[20]}}, dec_i.imm21, 12'h000};
        dest_d   = dec_i.rd;
        cnt_d    = CntFirst;
      end
    end else if (active_q) begin
      if (!stage_i.in_text) begin
        active_d = 1'b0;
        emit_o   = 1'b1;
      end else if (dec_i.rn == dest_q && dec_i.op != adrp_pkg::OP_NONE) begin
        active_d = 1'b0;
        emit_o   = 1'b1;
        found_o  = 1'b1;
        addr_o   = page_q + {49'd0, off_scaled};
      end else if (cnt_q >= CntLast) begin
        active_d = 1'b0;
        emit_o   = 1'b1;
      end else begin
        cnt_d = cnt_q + CntFirst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      page_q   <= '0;
      dest_q   <= '0;
      cnt_q    <= '0;
    end else if (advance_i) begin
      active_q <= active_d;
      page_q   <= page_d;
      dest_q   <= dest_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* hdl/adrp_pair_address_resolver.sv */
// ADRP pair address resolver. Instruction words enter in program order, one
// item per cycle; a start item (req_type 1) names an ADRP by function base and
// word index, and the following continue items (req_type 0) are searched for
// the first ADD immediate, 64-bit LDR or 32-bit LDR whose base register is the
// ADRP's destination. The block returns at most one result item per input
// item: found 1 with the page plus the scaled offset, or found 0 with a zero
// address when the start word is not an ADRP, a word lies outside text, or
// the window of WINDOW_LEN words (the ADRP included) runs out. A valid ADRP
// start and a non-matching word inside the window give no result, and a
// continue item with no search pending is simply consumed. Each item passes
// through an input register, and then decode, the 64-bit page and address
// adds and the search state update lead into the output register; a new item
// is taken in every cycle while the output side keeps up, and a result that
// waits to be taken stalls only items that would produce another result.
module adrp_pair_address_resolver #(
  parameter int unsigned WINDOW_LEN = adrp_pkg::WindowLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] instr_word_i,
  input  logic        word_in_text_i,
  input  logic [63:0] function_base_i,
  input  logic [31:0] word_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] resolved_address_o,
  output logic        found_o
);

  // Input register: the word's page address is formed on the way in, so
  // that the next stage need not add the function base and word index.
  logic              stage_valid_q;
  adrp_pkg::stage_t  stage_q, stage_d;
  adrp_pkg::decode_t dec;

  logic        emit;
  logic [63:0] addr;
  logic        found;
  logic        advance;
  logic        out_free;
  logic [63:0] pc;

  // Output register.
  logic        out_valid_q;
  logic [63:0] out_addr_q;
  logic        out_found_q;

  assign pc = function_base_i + {30'd0, word_index_i, 2'b00};

  always_comb begin
    stage_d.req_start = req_type_i;
    stage_d.in_text   = word_in_text_i;
    stage_d.word      = instr_word_i;
    stage_d.pc_page   = {pc[63:12], 12'h000};
  end

  // The held item moves on when it makes no result or the output slot is
  // free, so items that produce nothing never wait on the output side.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = stage_valid_q && (!emit || out_free);
  assign in_ready_o = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_q <= stage_d;
    end
  end

  adrp_decode u_decode (
    .word_i (stage_q.word),
    .dec_o  (dec)
  );

  adrp_search #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage_q),
    .dec_i     (dec),
    .advance_i (advance),
    .emit_o    (emit),
    .addr_o    (addr),
    .found_o   (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_addr_q  <= addr;
      out_found_q <= found;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign resolved_address_o = out_addr_q;
  assign found_o            = out_found_q;

endmodule
